>>> src/htwd_pkg.sv
`default_nettype none
package htwd_pkg;

	localparam int NODE_COUNT = 512;
	localparam int IDX_W      = 9;
	localparam int SYM_W      = 8;
	localparam int BYTE_W     = 8;
	localparam int CNT_W      = 4;
	localparam int MAX_BITS   = 8;
	localparam int ADDR_W     = $clog2(NODE_COUNT);

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_DECODE = 1'b1;

	typedef struct packed {
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic             leaf;
		logic [SYM_W-1:0] sym;
	} node_t;

	typedef struct packed {
		logic load_node;
		logic start_byte;
		logic step;
		logic emit;
		logic flush;
		logic cfg_wr;
	} cmd_t;

	typedef struct packed {
		logic leaf;
		logic bits_left;
		logic pend_v;
		logic out_free;
		logic dec_nonzero;
	} sts_t;

endpackage
`default_nettype wire

>>> src/huffman_tree_walk_decoder.sv
// Huffman decoder that walks a code tree held in a 512-entry node table.
// Input channel (in_valid / in_stall): req_type 0 writes one node (left_child,
// right_child, is_leaf, leaf_symbol at node_index). req_type 1 decodes
// code_byte, MSB first, valid_bits bits of it (at most 8); a 1 bit goes
// right, a 0 bit goes left, and each leaf reached yields one symbol.
// Output channel (out_valid / out_stall): one request per symbol, with
// last_of_run set on the last symbol of each input byte.
// Config channel (cfg_valid / cfg_ready): root_node, taken only while idle;
// writing it also restarts the walk at the new root.
// A decode request holds the input until its byte is done. Each bit costs one
// dependent read of the node table's single read port, and each leaf one more
// read to fetch the root again. A symbol is handed to the output only once the
// next leaf is reached or the byte is done.
// A stalled output holds its symbol; the walk waits when a further symbol
// must be handed on and the output register is still full.
// Reset clears the root and walk position to 0; the node table is not
// cleared and must be loaded before decoding.
`default_nettype none
module huffman_tree_walk_decoder (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         req_type,
	input  wire logic [htwd_pkg::IDX_W-1:0]   node_index,
	input  wire logic [htwd_pkg::IDX_W-1:0]   left_child,
	input  wire logic [htwd_pkg::IDX_W-1:0]   right_child,
	input  wire logic                         is_leaf,
	input  wire logic [htwd_pkg::SYM_W-1:0]   leaf_symbol,
	input  wire logic [htwd_pkg::BYTE_W-1:0]  code_byte,
	input  wire logic [htwd_pkg::CNT_W-1:0]   valid_bits,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [htwd_pkg::SYM_W-1:0]        symbol,
	output logic                              last_of_run,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [htwd_pkg::IDX_W-1:0]   root_node
);

	htwd_pkg::cmd_t cmd;
	htwd_pkg::sts_t sts;

	htwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.req_type  (req_type),
		.cfg_valid (cfg_valid),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready)
	);

	htwd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.node_index  (node_index),
		.left_child  (left_child),
		.right_child (right_child),
		.is_leaf     (is_leaf),
		.leaf_symbol (leaf_symbol),
		.code_byte   (code_byte),
		.valid_bits  (valid_bits),
		.root_node   (root_node),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.symbol      (symbol),
		.last_of_run (last_of_run)
	);

endmodule
`default_nettype wire

>>> src/htwd_ctrl.sv
`default_nettype none
module htwd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          req_type,
	input  wire logic          cfg_valid,
	input  wire htwd_pkg::sts_t sts,
	output htwd_pkg::cmd_t     cmd,
	output logic               in_stall,
	output logic               cfg_ready
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_WALK  = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cfg_ready  = 1'b1;
				cmd.cfg_wr = cfg_valid;
				if (in_valid) begin
					if (req_type == htwd_pkg::REQ_LOAD) begin
						cmd.load_node = 1'b1;
					end else if (sts.dec_nonzero) begin
						cmd.start_byte = 1'b1;
						state_d        = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				cmd.step = 1'b1;
				state_d  = ST_WALK;
			end
			ST_WALK: begin
				if (sts.leaf) begin
					if (!sts.pend_v || sts.out_free) begin
						cmd.emit = 1'b1;
						state_d  = sts.bits_left ? ST_FETCH : ST_FLUSH;
					end
				end else if (sts.bits_left) begin
					cmd.step = 1'b1;
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!sts.pend_v) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// an earlier symbol may only be pushed out when the output slot frees up
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && sts.pend_v |-> sts.out_free)
		else $error("symbol emitted over a blocked output");

	a_step_bits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> sts.bits_left)
		else $error("walk step with no bits left");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !sts.pend_v)
		else $error("pending symbol left behind at idle");

endmodule
`default_nettype wire

>>> src/htwd_dp.sv
`default_nettype none
module htwd_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire htwd_pkg::cmd_t               cmd,
	output htwd_pkg::sts_t                    sts,
	input  wire logic [htwd_pkg::IDX_W-1:0]   node_index,
	input  wire logic [htwd_pkg::IDX_W-1:0]   left_child,
	input  wire logic [htwd_pkg::IDX_W-1:0]   right_child,
	input  wire logic                         is_leaf,
	input  wire logic [htwd_pkg::SYM_W-1:0]   leaf_symbol,
	input  wire logic [htwd_pkg::BYTE_W-1:0]  code_byte,
	input  wire logic [htwd_pkg::CNT_W-1:0]   valid_bits,
	input  wire logic [htwd_pkg::IDX_W-1:0]   root_node,
	input  wire logic                         out_stall,
	output logic                              out_valid,
	output logic [htwd_pkg::SYM_W-1:0]        symbol,
	output logic                              last_of_run
);

	htwd_pkg::node_t node_mem_q [htwd_pkg::NODE_COUNT];
	htwd_pkg::node_t rd_node_q;
	htwd_pkg::node_t cur_node;
	logic                          rd_oob_q;
	logic [htwd_pkg::IDX_W-1:0]    rd_idx;
	logic                          rd_en;
	logic                          wr_in_range;
	logic                          rd_in_range;
	logic [htwd_pkg::IDX_W-1:0]    child;

	logic [htwd_pkg::IDX_W-1:0]    root_q;
	logic [htwd_pkg::IDX_W-1:0]    walk_q;
	logic [htwd_pkg::BYTE_W-1:0]   byte_q;
	logic [htwd_pkg::CNT_W-1:0]    count_q;
	logic [htwd_pkg::CNT_W-1:0]    count_init;
	logic                          pend_v_q;
	logic [htwd_pkg::SYM_W-1:0]    pend_sym_q;
	logic                          out_v_q;
	logic [htwd_pkg::SYM_W-1:0]    out_sym_q;
	logic                          out_last_q;
	logic                          push;

	assign wr_in_range = {1'b0, node_index} < (htwd_pkg::IDX_W+1)'(htwd_pkg::NODE_COUNT);
	assign rd_in_range = {1'b0, rd_idx} < (htwd_pkg::IDX_W+1)'(htwd_pkg::NODE_COUNT);

	// out-of-range indices read as an all-zero node
	assign cur_node = rd_oob_q ? '0 : rd_node_q;
	assign child    = byte_q[htwd_pkg::BYTE_W-1] ? cur_node.right : cur_node.left;

	always_comb begin
		rd_en  = cmd.start_byte | cmd.step | cmd.emit;
		rd_idx = walk_q;
		if (cmd.step) begin
			rd_idx = child;
		end else if (cmd.emit) begin
			rd_idx = root_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_node && wr_in_range) begin
			node_mem_q[node_index[htwd_pkg::ADDR_W-1:0]] <= '{
				left:  left_child,
				right: right_child,
				leaf:  is_leaf,
				sym:   leaf_symbol
			};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_node_q <= node_mem_q[rd_idx[htwd_pkg::ADDR_W-1:0]];
			rd_oob_q  <= !rd_in_range;
		end
	end

	assign count_init = (valid_bits > htwd_pkg::CNT_W'(htwd_pkg::MAX_BITS))
		? htwd_pkg::CNT_W'(htwd_pkg::MAX_BITS) : valid_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q  <= '0;
			walk_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.cfg_wr) begin
				root_q <= root_node;
				walk_q <= root_node;
			end else if (cmd.step) begin
				walk_q <= child;
			end else if (cmd.emit) begin
				walk_q <= root_q;
			end
			if (cmd.start_byte) begin
				count_q <= count_init;
			end else if (cmd.step) begin
				count_q <= count_q - htwd_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_byte) begin
			byte_q <= code_byte;
		end else if (cmd.step) begin
			byte_q <= {byte_q[htwd_pkg::BYTE_W-2:0], 1'b0};
		end
	end

	// a symbol waits in pend until we know whether it closes the byte
	assign push = (cmd.emit && pend_v_q) || cmd.flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.emit) begin
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
			if (push) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pend_sym_q <= cur_node.sym;
		end
		if (push) begin
			out_sym_q  <= pend_sym_q;
			out_last_q <= cmd.flush;
		end
	end

	assign sts.leaf        = cur_node.leaf;
	assign sts.bits_left   = count_q != '0;
	assign sts.pend_v      = pend_v_q;
	assign sts.out_free    = !out_v_q || !out_stall;
	assign sts.dec_nonzero = valid_bits != '0;

	assign out_valid   = out_v_q;
	assign symbol      = out_sym_q;
	assign last_of_run = out_last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= htwd_pkg::CNT_W'(htwd_pkg::MAX_BITS))
		else $error("bit count out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_stall |=> out_v_q && $stable(out_sym_q) && $stable(out_last_q))
		else $error("stalled output changed");

	a_flush_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> pend_v_q)
		else $error("flush with no pending symbol");

endmodule
`default_nettype wire
